### hdl/h264nf_pkg.sv
// shared types and constants of the h264 nal fragmenter
package h264nf_pkg;

   localparam int MTU_W        = 11;
   localparam int LEN_W        = 16;
   localparam int TS_W         = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;
   localparam int QUEUE_DEPTH  = 2;
   localparam int MAX_PACKETS  = 60;
   localparam int CNT_W        = $clog2(MAX_PACKETS);

   localparam logic [MTU_W-1:0] MTU_RESET = 11'd1436;
   localparam logic [MTU_W-1:0] MTU_FLOOR = 11'd1100;
   localparam logic [MTU_W-1:0] FU_BYTES  = 11'd2;
   localparam logic [4:0]       FU_A_TYPE = 5'd28;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_MTU_SIZE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_DECODE_TIME = 2'd1;

   typedef struct packed {
      logic [7:0]       nal_header;
      logic [LEN_W-1:0] nal_length;
      logic             last_nal;
      logic [TS_W-1:0]  decode_time;
      logic [TS_W-1:0]  composition_offset;
   } req_type;

   typedef struct packed {
      logic             has_fu_bytes;
      logic [7:0]       fu_indicator;
      logic [7:0]       fu_header;
      logic [LEN_W-1:0] payload_offset;
      logic [LEN_W-1:0] payload_length;
      logic [MTU_W-1:0] packet_length;
      logic             marker;
      logic [TS_W-1:0]  timestamp;
      logic             last_packet;
   } rsp_type;

   // one classified nal unit, handed from front to back
   typedef struct packed {
      logic             single;
      logic [7:0]       fu_indicator;
      logic [4:0]       nal_type;
      logic [LEN_W-1:0] nal_length;
      logic [LEN_W-1:0] remain;
      logic [MTU_W-1:0] chunk;
      logic [MTU_W-1:0] mtu;
      logic             last_nal;
      logic [TS_W-1:0]  timestamp;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hdl/h264_nal_fragmenter.sv
// top level of the h264 nal fragmenter (fu-a packet descriptors)
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_data   (nal unit descriptor)
//   rsp       out   rsp_valid/rsp_ready    rsp_data   (packet descriptor)
//   csr       in    csr_valid/csr_ready    csr_index, csr_data
//
// the back sequencer first loads a job from the queue, then emits one packet word per
// cycle while rsp_ready does not hold the output, up to 60 packet words per nal unit
// reset is synchronous; it empties the queue and output register and sets
// mtu_size to 1436 and use_decode_time to 0
// the front keeps accepting while the two-entry job queue has room
// rsp_ready low holds the output word and pauses the sequencer
module h264_nal_fragmenter #(
   parameter int QUEUE_DEPTH = h264nf_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  h264nf_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output h264nf_pkg::rsp_type                 rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [h264nf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [h264nf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import h264nf_pkg::*;

   q_status_type q_status;
   logic         q_push;
   logic         q_pop;
   job_type      push_job;
   job_type      pop_job;

   h264nf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   h264nf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   h264nf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/h264nf_front.sv
// front end: csr registers, input acceptance and nal unit classification
module h264nf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  h264nf_pkg::req_type                 req_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [h264nf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [h264nf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  h264nf_pkg::q_status_type            q_status,
   output logic                                q_push,
   output h264nf_pkg::job_type                 q_job
);
   import h264nf_pkg::*;

   logic [MTU_W-1:0] mtu_size_ff, mtu_size_in;
   logic             use_dts_ff, use_dts_in;
   logic [MTU_W-1:0] mtu;
   logic [MTU_W-1:0] chunk;

   assign csr_ready = 1'b1;

   always_comb begin
      mtu_size_in = mtu_size_ff;
      use_dts_in  = use_dts_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MTU_SIZE:        mtu_size_in = csr_data;
            CSR_USE_DECODE_TIME: use_dts_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_size_ff <= MTU_RESET;
         use_dts_ff  <= 1'b0;
      end else begin
         mtu_size_ff <= mtu_size_in;
         use_dts_ff  <= use_dts_in;
      end
   end

   // small mtu values are raised to the floor
   assign mtu   = (mtu_size_ff < MTU_FLOOR) ? MTU_FLOOR : mtu_size_ff;
   assign chunk = mtu - FU_BYTES;

   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_job.single       = req_data.nal_length <= LEN_W'(mtu);
      q_job.fu_indicator = {req_data.nal_header[7:5], FU_A_TYPE};
      q_job.nal_type     = req_data.nal_header[4:0];
      q_job.nal_length   = req_data.nal_length;
      // bytes left after the header byte and the start fragment
      q_job.remain       = req_data.nal_length - LEN_W'(1) - LEN_W'(chunk);
      q_job.chunk        = chunk;
      q_job.mtu          = mtu;
      q_job.last_nal     = req_data.last_nal;
      q_job.timestamp    = use_dts_ff ? req_data.decode_time
                                      : req_data.decode_time + req_data.composition_offset;
   end

endmodule

### hdl/h264nf_queue.sv
// short job queue between front and back
module h264nf_queue #(
   parameter int DEPTH = h264nf_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  h264nf_pkg::job_type       push_job,
   input  logic                      pop,
   output h264nf_pkg::job_type       pop_job,
   output h264nf_pkg::q_status_type  status
);
   import h264nf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_Q = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = (count_ff == CNT_Q'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_job      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### hdl/h264nf_back.sv
// back end: walks one nal unit and emits one packet word per cycle while the output is not held
module h264nf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  h264nf_pkg::q_status_type  q_status,
   input  h264nf_pkg::job_type       q_job,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output h264nf_pkg::rsp_type       rsp_data
);
   import h264nf_pkg::*;

   localparam logic [CNT_W-1:0] MID_LIMIT = CNT_W'(MAX_PACKETS - 1);

   logic             busy_ff, busy_in;
   logic             first_ff, first_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   job_type          job_ff, job_in;
   logic [LEN_W-1:0] off_ff, off_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   rsp_type          rsp_ff, rsp_in;
   logic             advance;
   logic             emit;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign emit      = busy_ff && advance;
   assign q_pop     = !busy_ff && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      off_in   = off_ff;
      rem_in   = rem_ff;
      rsp_in   = rsp_ff;

      rsp_in.timestamp    = job_ff.timestamp;
      rsp_in.fu_indicator = job_ff.fu_indicator;
      rsp_in.has_fu_bytes = 1'b1;
      rsp_in.marker       = 1'b0;
      rsp_in.last_packet  = 1'b0;

      if (q_pop) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         cnt_in   = '0;
         job_in   = q_job;
         rem_in   = q_job.remain;
      end else if (emit) begin
         if (job_ff.single) begin
            rsp_in.has_fu_bytes   = 1'b0;
            rsp_in.fu_indicator   = 8'h00;
            rsp_in.fu_header      = 8'h00;
            rsp_in.payload_offset = '0;
            rsp_in.payload_length = job_ff.nal_length;
            rsp_in.packet_length  = job_ff.nal_length[MTU_W-1:0];
            rsp_in.marker         = job_ff.last_nal;
            rsp_in.last_packet    = 1'b1;
            busy_in               = 1'b0;
         end else if (first_ff) begin
            // start fragment skips the nal header byte
            rsp_in.fu_header      = {3'b100, job_ff.nal_type};
            rsp_in.payload_offset = LEN_W'(1);
            rsp_in.payload_length = LEN_W'(job_ff.chunk);
            rsp_in.packet_length  = job_ff.mtu;
            off_in                = LEN_W'(1) + LEN_W'(job_ff.chunk);
            first_in              = 1'b0;
            cnt_in                = CNT_W'(1);
         end else if (rem_ff > LEN_W'(job_ff.chunk) && cnt_ff < MID_LIMIT) begin
            rsp_in.fu_header      = {3'b000, job_ff.nal_type};
            rsp_in.payload_offset = off_ff;
            rsp_in.payload_length = LEN_W'(job_ff.chunk);
            rsp_in.packet_length  = job_ff.mtu;
            off_in                = off_ff + LEN_W'(job_ff.chunk);
            rem_in                = rem_ff - LEN_W'(job_ff.chunk);
            cnt_in                = cnt_ff + 1'b1;
         end else begin
            rsp_in.fu_header      = {3'b010, job_ff.nal_type};
            rsp_in.payload_offset = off_ff;
            rsp_in.payload_length = rem_ff;
            rsp_in.packet_length  = rem_ff[MTU_W-1:0] + FU_BYTES;
            rsp_in.marker         = job_ff.last_nal;
            rsp_in.last_packet    = 1'b1;
            busy_in               = 1'b0;
         end
      end

      if (emit)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         first_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         first_ff     <= first_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      off_ff <= off_in;
      rem_ff <= rem_in;
      if (emit) rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MID_LIMIT)
      else $error("fragment count past limit");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_in.last_packet |=> !busy_ff)
      else $error("sequencer still busy after last packet");

   a_fu_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_fu_bytes |->
         rsp_ff.packet_length == rsp_ff.payload_length[MTU_W-1:0] + FU_BYTES)
      else $error("fu packet length mismatch");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> busy_ff && first_ff)
      else $error("job load did not start sequencer");
`endif

endmodule

### tb/sv/tb_h264_nal_fragmenter.sv
// self-checking testbench of the h264 nal fragmenter: directed cases, then random mixes
`timescale 1ns / 100ps

module tb_h264_nal_fragmenter;
   import h264nf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 70;

   // csr indexes that decode to no register
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   // top three bits of the fu header: start, end, reserved
   localparam logic [2:0] FU_START  = 3'b100;
   localparam logic [2:0] FU_MIDDLE = 3'b000;
   localparam logic [2:0] FU_END    = 3'b010;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor's copy of the registers
   logic [MTU_W-1:0]       mtu_reg = MTU_RESET;
   logic                   dts_only = 1'b0;

   rsp_type                pkt_q[$];
   int                     fail_count = 0;
   int                     nal_count = 0;
   int                     word_count = 0;
   int                     csr_count = 0;
   int                     cycle_count = 0;
   int                     tx_idle_pct = 0;
   int                     rx_stall_pct = 0;

   h264_nal_fragmenter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pkt_q.size());
         $display("** h264_nal_fragmenter: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   function automatic int unsigned eff_mtu();
      return (mtu_reg < MTU_FLOOR) ? MTU_FLOOR : mtu_reg;
   endfunction

   function automatic rsp_type packet_word(logic fu, logic [7:0] ind, logic [7:0] hdr,
                                           logic [LEN_W-1:0] off, logic [LEN_W-1:0] len,
                                           logic [MTU_W-1:0] plen, logic mark,
                                           logic [TS_W-1:0] stamp, logic last);
      rsp_type w;
      w.has_fu_bytes   = fu;
      w.fu_indicator   = ind;
      w.fu_header      = hdr;
      w.payload_offset = off;
      w.payload_length = len;
      w.packet_length  = plen;
      w.marker         = mark;
      w.timestamp      = stamp;
      w.last_packet    = last;
      return w;
   endfunction

   function automatic req_type nal_item(logic [7:0] hdr, logic [LEN_W-1:0] len, logic last,
                                        logic [TS_W-1:0] dts, logic [TS_W-1:0] cto);
      req_type n;
      n.nal_header         = hdr;
      n.nal_length         = len;
      n.last_nal           = last;
      n.decode_time        = dts;
      n.composition_offset = cto;
      return n;
   endfunction

   // expected packet words of one nal unit
   task automatic fragment_nal(input req_type nal);
      logic [TS_W-1:0] stamp;
      logic [7:0]      ind;
      logic [4:0]      kind;
      int unsigned     mtu, chunk, rem, off, k;
      stamp = dts_only ? nal.decode_time : nal.decode_time + nal.composition_offset;
      mtu = eff_mtu();
      if (nal.nal_length <= mtu) begin
         pkt_q.push_back(packet_word(1'b0, 8'h00, 8'h00, '0, nal.nal_length,
                                     nal.nal_length[MTU_W-1:0], nal.last_nal, stamp, 1'b1));
      end else begin
         ind   = {nal.nal_header[7:5], FU_A_TYPE};
         kind  = nal.nal_header[4:0];
         chunk = mtu - 2;
         off   = 1;
         rem   = nal.nal_length - 1 - chunk;
         pkt_q.push_back(packet_word(1'b1, ind, {FU_START, kind}, LEN_W'(off),
                                     LEN_W'(chunk), MTU_W'(mtu), 1'b0, stamp, 1'b0));
         off += chunk;
         k = 1;
         while (rem > chunk && k < MAX_PACKETS - 1) begin
            pkt_q.push_back(packet_word(1'b1, ind, {FU_MIDDLE, kind}, LEN_W'(off),
                                        LEN_W'(chunk), MTU_W'(mtu), 1'b0, stamp, 1'b0));
            off += chunk;
            rem -= chunk;
            k++;
         end
         pkt_q.push_back(packet_word(1'b1, ind, {FU_END, kind}, LEN_W'(off), LEN_W'(rem),
                                     MTU_W'(rem + 2), nal.last_nal, stamp, 1'b1));
      end
   endtask

   task automatic compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         word_count++;
         if (pkt_q.size() == 0) begin
            $error("unexpected packet word 0x%0h", rsp_data);
            fail_count++;
         end else begin
            want = pkt_q.pop_front();
            compare_field("has_fu_bytes", want.has_fu_bytes, rsp_data.has_fu_bytes);
            compare_field("fu_indicator", want.fu_indicator, rsp_data.fu_indicator);
            compare_field("fu_header", want.fu_header, rsp_data.fu_header);
            compare_field("payload_offset", want.payload_offset, rsp_data.payload_offset);
            compare_field("payload_length", want.payload_length, rsp_data.payload_length);
            compare_field("packet_length", want.packet_length, rsp_data.packet_length);
            compare_field("marker", want.marker, rsp_data.marker);
            compare_field("timestamp", want.timestamp, rsp_data.timestamp);
            compare_field("last_packet", want.last_packet, rsp_data.last_packet);
         end
      end
   end

   task automatic send_nal(input req_type nal);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= nal;
      do @(posedge clock); while (!req_ready);
      fragment_nal(nal);
      nal_count++;
   endtask

   // drop valid and wait until every expected word has come back
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pkt_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      quiesce();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MTU_SIZE:        mtu_reg  = val;
         CSR_USE_DECODE_TIME: dts_only = val[0];
         default: ;
      endcase
      csr_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [LEN_W-1:0] random_length();
      int unsigned m, r;
      m = eff_mtu();
      r = $urandom_range(99);
      if (r < 2)       return '0;
      else if (r < 35) return LEN_W'($urandom_range(m, 1));
      else if (r < 42) return LEN_W'($urandom_range(m + 2, m - 1));
      else if (r < 78) return LEN_W'($urandom_range(5 * m, m + 1));
      else if (r < 94) return LEN_W'($urandom_range(20 * m, m + 1));
      else             return LEN_W'($urandom_range(65535, 40000));
   endfunction

   function automatic req_type random_nal();
      logic [TS_W-1:0] cto;
      cto = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(9000);
      return nal_item(8'($urandom_range(255)), random_length(), 1'($urandom_range(1)),
                      $urandom(), cto);
   endfunction

   task automatic random_settings();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 6)      write_reg(CSR_MTU_SIZE, CSR_DATA_W'($urandom_range(1500, 1100)));
      else if (r < 8) write_reg(CSR_MTU_SIZE, CSR_DATA_W'($urandom_range(1099, 0)));
      else            write_reg(CSR_MTU_SIZE, CSR_DATA_W'($urandom_range(2047, 1501)));
      write_reg(CSR_USE_DECODE_TIME, CSR_DATA_W'($urandom_range(2047)));
   endtask

   task automatic test_reset_values();
      send_nal(nal_item(8'h65, 16'd1436, 1'b0, 32'd1000, 32'd3000));
      send_nal(nal_item(8'hFF, 16'd1437, 1'b1, 32'd90000, 32'd0));
      send_nal(nal_item(8'h41, 16'd700, 1'b1, 32'hFFFF_FFFF, 32'd2));
   endtask

   task automatic test_single_packet();
      write_reg(CSR_MTU_SIZE, 11'd1500);
      send_nal(nal_item(8'h00, 16'd0, 1'b0, 32'd0, 32'd0));
      send_nal(nal_item(8'h09, 16'd1, 1'b1, 32'd12345, 32'd3003));
      send_nal(nal_item(8'hFF, 16'd1500, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_nal(nal_item(8'h00, 16'd1501, 1'b0, 32'd0, 32'hFFFF_FFFF));
   endtask

   task automatic test_small_mtu();
      write_reg(CSR_MTU_SIZE, MTU_FLOOR);
      send_nal(nal_item(8'h7C, 16'hFFFF, 1'b1, 32'hDEAD_BEEF, 32'd6006));
      send_nal(nal_item(8'h25, 16'd1101, 1'b0, 32'd450, 32'd1));
      // values under the floor act as the floor
      write_reg(CSR_MTU_SIZE, 11'd0);
      send_nal(nal_item(8'hA5, 16'd1101, 1'b1, 32'd7, 32'd8));
      send_nal(nal_item(8'h61, 16'd1100, 1'b0, 32'd9, 32'd10));
      write_reg(CSR_MTU_SIZE, 11'd1099);
      send_nal(nal_item(8'hE1, 16'hFFFF, 1'b0, 32'd0, 32'hFFFF_FFFF));
   endtask

   task automatic test_large_mtu();
      write_reg(CSR_MTU_SIZE, 11'h7FF);
      send_nal(nal_item(8'h1F, 16'd2047, 1'b1, 32'd100, 32'd200));
      send_nal(nal_item(8'h3E, 16'd2048, 1'b0, 32'd300, 32'd400));
      send_nal(nal_item(8'h9B, 16'hFFFF, 1'b1, 32'h8000_0000, 32'h8000_0000));
   endtask

   task automatic test_decode_time();
      write_reg(CSR_MTU_SIZE, MTU_RESET);
      write_reg(CSR_USE_DECODE_TIME, 11'h7FF);
      send_nal(nal_item(8'h65, 16'd5000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_nal(nal_item(8'h01, 16'd20, 1'b0, 32'h1234_5678, 32'd3000));
      write_reg(CSR_USE_DECODE_TIME, 11'h000);
   endtask

   // writes to undecoded indexes must leave both registers alone
   task automatic test_spare_index();
      write_reg(CSR_SPARE_2, 11'h7FF);
      write_reg(CSR_SPARE_3, 11'h001);
      write_reg(CSR_SPARE_3, 11'h7FE);
      send_nal(nal_item(8'h45, 16'd1500, 1'b1, 32'd5000, 32'd1500));
   endtask

   task automatic test_drain_pause();
      random_settings();
      for (int i = 0; i < 12; i++) begin
         send_nal(random_nal());
         if (i % 4 == 3) quiesce();
      end
   endtask

   task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n);
      tx_idle_pct  = idle_pct;
      rx_stall_pct = stall_pct;
      for (int s = 0; s < 2; s++) begin
         random_settings();
         for (int i = 0; i < n / 2; i++) send_nal(random_nal());
      end
      quiesce();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_single_packet();
      test_small_mtu();
      test_large_mtu();
      test_decode_time();
      test_spare_index();
      test_drain_pause();
      test_random_mix(0, 0, 50);
      test_random_mix(79, 0, 50);
      test_random_mix(0, 79, 50);
      test_random_mix(37, 37, 50);

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d nal units and %0d packet words across %0d register writes,",
               nal_count, word_count, csr_count);
      $display("with mtu below, at and above its range and four sender/receiver idle mixes");
      if (fail_count == 0 && pkt_q.size() == 0) begin
         $display("** h264_nal_fragmenter: PASSED **");
      end else begin
         if (pkt_q.size() != 0) $error("%0d expected packet words never arrived", pkt_q.size());
         $display("** h264_nal_fragmenter: FAILED **");
      end
      $finish;
   end

endmodule

### h264_nal_fragmenter.f
hdl/h264nf_pkg.sv
hdl/h264nf_front.sv
hdl/h264nf_queue.sv
hdl/h264nf_back.sv
hdl/h264_nal_fragmenter.sv
tb/sv/tb_h264_nal_fragmenter.sv
